// ===== sv/fpdt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the frame pacing timer.
package fpdt_pkg;

    localparam int TIME_WIDTH_DEF = 48;
    localparam int RATE_WIDTH_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int FPS_W      = 16;
    localparam int FREQ_W     = 30;
    localparam int THR_W      = 16;
    localparam int ELAPSED_W  = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FREQ_W;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_FREQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNCAPPED_FPS = 1'd1;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 30'd10000000;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd65535;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic inc_now;
        logic clr_pace;
        logic load_div;
        logic div_step;
        logic apply;
        logic bypass_rel;
        logic paced_rel;
        logic fix;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic uncapped;
        logic div_last;
        logic due;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/fpdt_ctrl.sv =====
// Sequencing state machine of the frame pacing timer.
module fpdt_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [fpdt_pkg::CMD_W-1:0] cmd,
    input  fpdt_pkg::dp_status_t      status,
    output fpdt_pkg::ctrl_cmd_t       ctrl
);
    import fpdt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BYPASS,
        ST_DIV,
        ST_APPLY,
        ST_CHECK,
        ST_FIX
    } state_t;

    state_t state_reg, state_next;
    logic   waiting_reg, waiting_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        waiting_next = waiting_reg;
        ctrl         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_TICK:
                        begin
                            ctrl.inc_now = 1'b1;
                            if (waiting_reg)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        CMD_REQUEST:
                        begin
                            // drop requests while a frame is pending
                            if (!waiting_reg)
                            begin
                                if (status.uncapped)
                                begin
                                    state_next = ST_BYPASS;
                                end
                                else
                                begin
                                    ctrl.load_div = 1'b1;
                                    state_next    = ST_DIV;
                                end
                            end
                        end
                        CMD_RESET:
                        begin
                            ctrl.clr_pace = 1'b1;
                            waiting_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BYPASS:
            begin
                if (status.out_free)
                begin
                    ctrl.bypass_rel = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                ctrl.apply = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.due)
                begin
                    // hold until the output beat slot is free
                    if (status.out_free)
                    begin
                        ctrl.paced_rel = 1'b1;
                        waiting_next   = 1'b0;
                        state_next     = ST_FIX;
                    end
                end
                else
                begin
                    waiting_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FIX:
            begin
                ctrl.fix   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            waiting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            waiting_reg <= waiting_next;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.inc_now, ctrl.clr_pace, ctrl.load_div, ctrl.div_step,
                  ctrl.apply, ctrl.bypass_rel, ctrl.paced_rel, ctrl.fix}))
        else $error("more than one datapath command at once");

    a_rel_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.paced_rel || ctrl.bypass_rel) |-> status.out_free)
        else $error("release issued while output beat is held");

    a_div_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_BYPASS) |-> !waiting_reg)
        else $error("new frame started while one is pending");
`endif

endmodule

// ===== sv/fpdt_datapath.sv =====
// Time base, deadline arithmetic, period divider and output register of the frame pacing timer.
module fpdt_datapath
#(
    parameter int TIME_WIDTH = fpdt_pkg::TIME_WIDTH_DEF,
    parameter int RATE_WIDTH = fpdt_pkg::RATE_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fpdt_pkg::FPS_W-1:0]        fps,
    input  logic                              cfg_we,
    input  logic [fpdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpdt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [fpdt_pkg::ELAPSED_W-1:0]    elapsed_ticks,
    output logic                              paced,
    input  fpdt_pkg::ctrl_cmd_t               ctrl,
    output fpdt_pkg::dp_status_t              status
);
    import fpdt_pkg::*;

    localparam int CMP_W = (RATE_WIDTH > THR_W) ? RATE_WIDTH : THR_W;
    localparam int CNT_W = $clog2(FREQ_W + 1);

    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;
    logic [TIME_WIDTH-1:0] dl_reg, dl_next;
    logic [FREQ_W-1:0]     period_reg, period_next;
    logic [RATE_WIDTH-1:0] last_rate_reg, last_rate_next;
    logic [FREQ_W-1:0]     freq_reg, freq_next;
    logic [THR_W-1:0]      thr_reg, thr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;

    logic [RATE_WIDTH-1:0] rate_reg, rate_next;
    logic [FREQ_W-1:0]     q_reg, q_next;
    logic [RATE_WIDTH-1:0] rem_reg, rem_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                  paced_reg, paced_next;

    logic [RATE_WIDTH-1:0] rate_in;
    logic [TIME_WIDTH-1:0] period_ext;
    logic [TIME_WIDTH-1:0] quot_ext;
    logic [TIME_WIDTH-1:0] diff_now_dl;
    logic [TIME_WIDTH-1:0] diff_start_dl;
    logic [TIME_WIDTH-1:0] diff_dl_now;
    logic [TIME_WIDTH-1:0] since_start;
    logic [TIME_WIDTH-1:0] anchor;
    logic [TIME_WIDTH-1:0] dl_adv;
    logic [RATE_WIDTH:0]   trial;
    logic [RATE_WIDTH:0]   trial_sub;
    logic                  trial_ge;

    assign rate_in    = RATE_WIDTH'(fps);
    assign period_ext = TIME_WIDTH'(period_reg);
    assign quot_ext   = TIME_WIDTH'(q_reg);

    // Wrapping time compares: a has reached b when a - b is not negative
    assign diff_now_dl   = now_reg - dl_reg;
    assign diff_start_dl = start_reg - dl_reg;
    assign diff_dl_now   = dl_reg - now_reg;
    assign since_start   = now_reg - start_reg;
    assign anchor        = now_reg + period_ext;
    assign dl_adv        = dl_reg + period_ext;

    // Restoring divider, one quotient bit per step
    assign trial     = {rem_reg, q_reg[FREQ_W-1]};
    assign trial_ge  = (trial >= {1'b0, rate_reg});
    assign trial_sub = trial - {1'b0, rate_reg};

    assign status.uncapped = (rate_in == '0) || (CMP_W'(rate_in) >= CMP_W'(thr_reg));
    assign status.div_last = (cnt_reg == CNT_W'(FREQ_W - 1));
    assign status.due      = !diff_now_dl[TIME_WIDTH-1];
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign elapsed_ticks = elapsed_reg;
    assign paced         = paced_reg;

    always_comb
    begin
        now_next       = now_reg;
        start_next     = start_reg;
        dl_next        = dl_reg;
        period_next    = period_reg;
        last_rate_next = last_rate_reg;
        freq_next      = freq_reg;
        thr_next       = thr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        rate_next      = rate_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        elapsed_next   = elapsed_reg;
        paced_next     = paced_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COUNTER_FREQ: freq_next = cfg_data;
                REG_UNCAPPED_FPS: thr_next  = cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ctrl.inc_now)
        begin
            now_next = now_reg + TIME_WIDTH'(1);
        end

        if (ctrl.clr_pace)
        begin
            start_next     = now_reg;
            dl_next        = now_reg;
            last_rate_next = '0;
        end

        if (ctrl.load_div)
        begin
            rate_next = rate_in;
            q_next    = freq_reg;
            rem_next  = '0;
            cnt_next  = '0;
        end

        if (ctrl.div_step)
        begin
            rem_next = trial_ge ? trial_sub[RATE_WIDTH-1:0] : trial[RATE_WIDTH-1:0];
            q_next   = {q_reg[FREQ_W-2:0], trial_ge};
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (ctrl.apply)
        begin
            period_next = q_reg;
            // re-anchor on a rate change or when the deadline has not moved past the start
            if ((rate_reg != last_rate_reg) || !diff_start_dl[TIME_WIDTH-1])
            begin
                last_rate_next = rate_reg;
                dl_next        = now_reg + quot_ext;
            end
        end

        if (ctrl.bypass_rel)
        begin
            elapsed_next   = ELAPSED_W'(since_start);
            paced_next     = 1'b0;
            out_valid_next = 1'b1;
            start_next     = now_reg;
            dl_next        = now_reg;
            last_rate_next = '0;
        end

        if (ctrl.paced_rel)
        begin
            elapsed_next   = ELAPSED_W'(since_start);
            paced_next     = 1'b1;
            out_valid_next = 1'b1;
            start_next     = now_reg;
            dl_next        = dl_adv;
        end

        // stall recovery: pull the deadline forward if it is not strictly ahead
        if (ctrl.fix)
        begin
            if (diff_dl_now[TIME_WIDTH-1] || (dl_reg == now_reg))
            begin
                dl_next = anchor;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            start_reg     <= '0;
            dl_reg        <= '0;
            period_reg    <= '0;
            last_rate_reg <= '0;
            freq_reg      <= FREQ_RESET;
            thr_reg       <= THR_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            now_reg       <= now_next;
            start_reg     <= start_next;
            dl_reg        <= dl_next;
            period_reg    <= period_next;
            last_rate_reg <= last_rate_next;
            freq_reg      <= freq_next;
            thr_reg       <= thr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg    <= rate_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        elapsed_reg <= elapsed_next;
        paced_reg   <= paced_next;
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(ctrl.bypass_rel || ctrl.paced_rel))
        else $error("output beat overwritten before it was taken");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |-> (rem_reg < rate_reg))
        else $error("divider remainder not below divisor");

    a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.apply |-> (cnt_reg == CNT_W'(FREQ_W)))
        else $error("period taken before divider finished");
`endif

endmodule

// ===== sv/frame_pacing_deadline_timer.sv =====
// Frame pacing deadline timer top level: controller and datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------
//  in      | input     | in_valid / in_ready    | cmd, fps
//  out     | output    | out_valid / out_ready  | elapsed_ticks, paced
//  cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// Tick, reset and unused commands leave the controller idle; a tick with a frame pending
// visits check, and fix if it releases. A bypassed request visits the bypass state; a paced
// request runs the one-bit-per-cycle restoring divider over the 30-bit counter_freq, then
// apply, check and fix if released at once. Reset is asynchronous and needs no clearing
// pass. A release holds while the previous result beat waits at the output register.
module frame_pacing_deadline_timer
#(
    parameter int TIME_WIDTH = fpdt_pkg::TIME_WIDTH_DEF,
    parameter int RATE_WIDTH = fpdt_pkg::RATE_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fpdt_pkg::CMD_W-1:0]        cmd,
    input  logic [fpdt_pkg::FPS_W-1:0]        fps,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fpdt_pkg::ELAPSED_W-1:0]    elapsed_ticks,
    output logic                              paced,
    input  logic                              cfg_we,
    input  logic [fpdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpdt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fpdt_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    fpdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status),
        .ctrl     (ctrl)
    );

    fpdt_datapath
    #(
        .TIME_WIDTH (TIME_WIDTH),
        .RATE_WIDTH (RATE_WIDTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fps           (fps),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .elapsed_ticks (elapsed_ticks),
        .paced         (paced),
        .ctrl          (ctrl),
        .status        (status)
    );

endmodule

// ===== test/tb_frame_pacing_deadline_timer.sv =====
// Testbench for the frame pacing deadline timer: directed and random beats checked by a predictor.
`timescale 1ns / 100ps

module tb_frame_pacing_deadline_timer;
    import fpdt_pkg::*;

    localparam int TW           = TIME_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_BEATS  = 140;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef logic [TW-1:0] tick_t;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [FPS_W-1:0] rate;
    } pace_item_t;

    typedef struct {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 by_deadline;
    } frame_release_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd = CMD_TICK;
    logic [FPS_W-1:0]      fps = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ELAPSED_W-1:0]  elapsed_ticks;
    logic                  paced;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and its copy of the registers
    tick_t             now_cnt, frame_start, deadline, period;
    logic [FPS_W-1:0]  last_rate;
    logic              waiting;
    logic [FREQ_W-1:0] freq_cfg;
    logic [THR_W-1:0]  thr_cfg;

    pace_item_t     pending_q[$];
    frame_release_t release_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_gen = 0;
    int n_beats = 0;
    int n_paced = 0;
    int n_bypass = 0;
    int n_settings = 0;
    int err_count = 0;
    int idle_cycles = 0;

    frame_pacing_deadline_timer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .fps          (fps),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .elapsed_ticks(elapsed_ticks),
        .paced        (paced),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit has_reached(tick_t a, tick_t b);
        tick_t d;
        d = a - b;
        return ~d[TW-1];
    endfunction

    function automatic void release_frame(bit by_dl);
        frame_release_t r;
        r.elapsed     = now_cnt - frame_start;
        r.by_deadline = by_dl;
        release_q.push_back(r);
        frame_start = now_cnt;
        waiting     = 1'b0;
        if (by_dl)
        begin
            deadline = deadline + period;
            // stall recovery: re-anchor a deadline that is already due
            if (!has_reached(deadline, now_cnt) || deadline == now_cnt)
                deadline = now_cnt + period;
        end
    endfunction

    function automatic void pace_step(logic [CMD_W-1:0] op, logic [FPS_W-1:0] rate);
        case (op)
            CMD_TICK:
            begin
                now_cnt = now_cnt + tick_t'(1);
                if (waiting && has_reached(now_cnt, deadline))
                    release_frame(1'b1);
            end
            CMD_REQUEST:
            begin
                if (!waiting)
                begin
                    if (rate == '0 || rate >= thr_cfg)
                    begin
                        release_frame(1'b0);
                        deadline  = now_cnt;
                        last_rate = '0;
                    end
                    else
                    begin
                        period = tick_t'(freq_cfg / rate);
                        if (last_rate != rate || has_reached(frame_start, deadline))
                        begin
                            last_rate = rate;
                            deadline  = now_cnt + period;
                        end
                        if (has_reached(now_cnt, deadline))
                            release_frame(1'b1);
                        else
                            waiting = 1'b1;
                    end
                end
            end
            CMD_RESET:
            begin
                frame_start = now_cnt;
                deadline    = now_cnt;
                last_rate   = '0;
                waiting     = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [ELAPSED_W-1:0] got,
                                   logic [ELAPSED_W-1:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic void push_item(logic [CMD_W-1:0] op, logic [FPS_W-1:0] rate);
        pace_item_t it;
        it.op   = op;
        it.rate = rate;
        pending_q.push_back(it);
        if (op != CMD_UNUSED)
            n_gen++;
    endfunction

    function automatic void push_ticks(int n);
        for (int i = 0; i < n; i++)
            push_item(CMD_TICK, logic'($urandom) ? 16'hFFFF : 16'h0000);
    endfunction

    function automatic void set_idling(int m);
        case (m)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_COUNTER_FREQ)
            freq_cfg = data[FREQ_W-1:0];
        else
            thr_cfg = data[THR_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // wait until everything sent has been accepted and checked, then let the block drain
    task automatic settle();
        while (pending_q.size() != 0 || in_valid || release_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin : drive_in
        pace_item_t nxt;
        if (rst_n && in_valid && in_ready)
        begin
            pace_step(cmd, fps);
            n_beats++;
        end
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_q.pop_front();
                in_valid <= 1'b1;
                cmd      <= nxt.op;
                fps      <= nxt.rate;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk)
    begin : watch_out
        frame_release_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (release_q.size() == 0)
                report_mismatch("release with none pending", elapsed_ticks, '0);
            else
            begin
                want = release_q.pop_front();
                if (elapsed_ticks !== want.elapsed)
                    report_mismatch("elapsed_ticks", elapsed_ticks, want.elapsed);
                if (paced !== want.by_deadline)
                    report_mismatch("paced", paced, want.by_deadline);
                if (want.by_deadline)
                    n_paced++;
                else
                    n_bypass++;
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned freq, thr, lo, hi, est, n, pick;
        logic [FPS_W-1:0] rate, prev_rate;

        now_cnt     = '0;
        frame_start = '0;
        deadline    = '0;
        period      = '0;
        last_rate   = '0;
        waiting     = 1'b0;
        freq_cfg    = FREQ_RESET;
        thr_cfg     = THR_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bypass, ignore and drop under the reset settings
        set_idling(0);
        push_item(CMD_REQUEST, 16'd0);
        push_ticks(2);
        push_item(CMD_REQUEST, 16'd65535);
        push_item(CMD_UNUSED, 16'hFFFF);
        push_item(CMD_REQUEST, 16'd65534);
        push_item(CMD_REQUEST, 16'd1);
        push_item(CMD_RESET, 16'd0);
        push_ticks(1);
        push_item(CMD_REQUEST, 16'd0);
        settle();

        // short periods: release on tick, on request, and zero period from a small frequency
        write_reg(REG_COUNTER_FREQ, 30'd40);
        write_reg(REG_UNCAPPED_FPS, 30'd50);
        push_item(CMD_REQUEST, 16'd4);
        push_ticks(10);
        push_item(CMD_REQUEST, 16'd4);
        push_ticks(15);
        push_item(CMD_REQUEST, 16'd4);
        push_ticks(25);
        push_item(CMD_REQUEST, 16'd4);
        push_item(CMD_REQUEST, 16'd50);
        push_item(CMD_REQUEST, 16'd49);
        push_item(CMD_REQUEST, 16'd40);
        push_ticks(1);
        settle();

        // zero frequency, zero threshold, unit frequency
        write_reg(REG_COUNTER_FREQ, 30'd0);
        push_item(CMD_REQUEST, 16'd7);
        push_item(CMD_REQUEST, 16'd7);
        settle();
        write_reg(REG_UNCAPPED_FPS, 30'd0);
        push_item(CMD_REQUEST, 16'd1);
        push_item(CMD_REQUEST, 16'd65535);
        settle();
        write_reg(REG_COUNTER_FREQ, 30'd1);
        write_reg(REG_UNCAPPED_FPS, 30'd1);
        push_item(CMD_REQUEST, 16'd1);
        settle();
        write_reg(REG_UNCAPPED_FPS, 30'd65535);
        push_item(CMD_REQUEST, 16'd1);
        push_ticks(1);
        settle();

        // widest frequency: a long paced period, a few ticks, then a drop
        write_reg(REG_COUNTER_FREQ, 30'h3FFF_FFFF);
        push_item(CMD_REQUEST, 16'd65534);
        push_ticks(20);
        push_item(CMD_REQUEST, 16'd65534);
        push_item(CMD_RESET, 16'd0);
        settle();
        write_reg(REG_COUNTER_FREQ, 30'd1000000000);
        push_item(CMD_REQUEST, 16'd1);
        push_item(CMD_RESET, 16'd0);
        push_item(CMD_REQUEST, 16'd65535);
        settle();

        // random phases
        for (int ph = 0; ph < 12; ph++)
        begin
            set_idling(ph % 4);
            freq = ($urandom_range(3) == 0) ? $urandom_range(1, 60) : $urandom_range(60, 1500);
            lo   = freq / 32 + 1;
            case (ph % 3)
                0: thr = 65535;
                1: thr = $urandom_range(1, 65535);
                default: thr = lo + $urandom_range(1, 200);
            endcase
            write_reg(REG_COUNTER_FREQ, CFG_DATA_W'(freq));
            write_reg(REG_UNCAPPED_FPS, CFG_DATA_W'(thr));
            prev_rate = '0;
            n_gen     = 0;
            while (n_gen < PHASE_BEATS)
            begin
                pick = $urandom_range(99);
                if (pick < 60 && thr > lo)
                begin
                    // well-formed run: request, then ticks around its period
                    hi = thr - 1;
                    if ($urandom_range(9) != 0 && hi > lo * 4 + 8)
                        hi = lo * 4 + 8;
                    if (prev_rate != '0 && $urandom_range(1) == 1)
                        rate = prev_rate;
                    else
                        rate = FPS_W'($urandom_range(lo, hi));
                    prev_rate = rate;
                    push_item(CMD_REQUEST, rate);
                    est = freq / rate;
                    n   = $urandom_range(0, est + est / 2 + 2);
                    if ($urandom_range(5) == 0)
                    begin
                        push_ticks(n / 2);
                        push_item(CMD_REQUEST, FPS_W'($urandom));
                        push_ticks(n - n / 2);
                    end
                    else
                        push_ticks(n);
                end
                else if (pick < 75)
                begin
                    case ($urandom_range(3))
                        0: push_item(CMD_REQUEST, 16'd0);
                        3: push_item(CMD_REQUEST, FPS_W'($urandom));
                        default: push_item(CMD_REQUEST, FPS_W'($urandom_range(thr, 65535)));
                    endcase
                end
                else if (pick < 85)
                    push_item(CMD_RESET, FPS_W'($urandom));
                else if (pick < 95)
                    push_ticks($urandom_range(1, 6));
                else
                    push_item(CMD_UNUSED, FPS_W'($urandom));
            end
            settle();
        end

        $display("run covered %0d input beats over %0d register writes", n_beats, n_settings);
        $display("releases checked: %0d paced, %0d bypassed", n_paced, n_bypass);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
